// File: rtl/qlbg_pkg.sv
`timescale 1ns / 1ps
package qlbg_pkg;

  localparam int unsigned MAX_POSITIONS = 8;
  localparam int unsigned POS_W         = 3;
  localparam int unsigned ADDR_W        = 6;
  localparam int unsigned DATA_W        = 64;

  // register indexes
  localparam logic [2:0] REG_COST_LO  = 3'd0;
  localparam logic [2:0] REG_COST_HI  = 3'd1;
  localparam logic [2:0] REG_LENGTH   = 3'd2;
  localparam logic [2:0] REG_BASE     = 3'd3;
  localparam logic [2:0] REG_RESMIN   = 3'd4;
  localparam logic [2:0] REG_ALPHA    = 3'd5;
  localparam logic [2:0] REG_MARGINS  = 3'd6;
  localparam logic [2:0] REG_DWELL    = 3'd7;

  localparam logic [63:0] COST_RST    = 64'h8000_8000_8000_8000;
  localparam logic [3:0]  LENGTH_RST  = 4'd1;
  localparam logic [15:0] BASE_RST    = 16'd256;
  localparam logic [15:0] RESMIN_RST  = 16'd0;
  localparam logic [15:0] ALPHA_RST   = 16'd6554;
  localparam logic [31:0] MARGINS_RST = 32'h4000_4000;
  localparam logic [7:0]  DWELL_RST   = 8'd0;

  // datapath operations, one per controller step
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_PRE     = 4'd2;
  localparam logic [3:0] OP_MUL1    = 4'd3;
  localparam logic [3:0] OP_MUL2    = 4'd4;
  localparam logic [3:0] OP_DIVINIT = 4'd5;
  localparam logic [3:0] OP_DIVSTEP = 4'd6;
  localparam logic [3:0] OP_DIVEND  = 4'd7;
  localparam logic [3:0] OP_TIGHT   = 4'd8;
  localparam logic [3:0] OP_RPRED   = 4'd9;
  localparam logic [3:0] OP_RFIT    = 4'd10;
  localparam logic [3:0] OP_PRED    = 4'd11;
  localparam logic [3:0] OP_OUT     = 4'd12;

  typedef struct packed {
    logic [63:0] cost_lo;
    logic [63:0] cost_hi;
    logic [3:0]  length;
    logic [15:0] base;
    logic [15:0] resmin;
    logic [15:0] alpha;
    logic [31:0] margins;
    logic [7:0]  dwell;
  } cfg_t;

  typedef struct packed {
    logic        seed;
    logic [15:0] seed_val;
    logic        dwell_ld;
    logic [7:0]  dwell_val;
  } cfg_evt_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic meas_ok;
    logic seen;
    logic cost_zero;
    logic div_last;
    logic pinned;
    logic relax_go;
  } sts_t;

  function automatic logic [POS_W-1:0] last_pos(input logic [3:0] len);
    logic [POS_W-1:0] r;
    if (len == 4'd0) begin
      r = '0;
    end else if (len > 4'(MAX_POSITIONS)) begin
      r = POS_W'(MAX_POSITIONS - 1);
    end else begin
      r = POS_W'(len - 4'd1);
    end
    return r;
  endfunction

  function automatic logic [15:0] cost_of(input cfg_t c, input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] last;
    logic [POS_W-1:0] idx;
    logic [15:0]      w;
    last = last_pos(c.length);
    idx  = (pos < last) ? pos : last;
    case (idx)
      3'd0: w = c.cost_lo[15:0];
      3'd1: w = c.cost_lo[31:16];
      3'd2: w = c.cost_lo[47:32];
      3'd3: w = c.cost_lo[63:48];
      3'd4: w = c.cost_hi[15:0];
      3'd5: w = c.cost_hi[31:16];
      3'd6: w = c.cost_hi[47:32];
      3'd7: w = c.cost_hi[63:48];
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/qlbg_regs.sv
`timescale 1ns / 1ps
module qlbg_regs import qlbg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output cfg_evt_t          evt
);

  cfg_t       cfg_r, cfg_nxt;
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[5:3];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_COST_LO: cfg_nxt.cost_lo = pwdata;
        REG_COST_HI: cfg_nxt.cost_hi = pwdata;
        REG_LENGTH:  cfg_nxt.length  = pwdata[3:0];
        REG_BASE:    cfg_nxt.base    = pwdata[15:0];
        REG_RESMIN:  cfg_nxt.resmin  = pwdata[15:0];
        REG_ALPHA:   cfg_nxt.alpha   = pwdata[15:0];
        REG_MARGINS: cfg_nxt.margins = pwdata[31:0];
        REG_DWELL:   cfg_nxt.dwell   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cost_lo <= COST_RST;
      cfg_r.cost_hi <= COST_RST;
      cfg_r.length  <= LENGTH_RST;
      cfg_r.base    <= BASE_RST;
      cfg_r.resmin  <= RESMIN_RST;
      cfg_r.alpha   <= ALPHA_RST;
      cfg_r.margins <= MARGINS_RST;
      cfg_r.dwell   <= DWELL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_COST_LO: prdata = cfg_r.cost_lo;
      REG_COST_HI: prdata = cfg_r.cost_hi;
      REG_LENGTH:  prdata = {60'd0, cfg_r.length};
      REG_BASE:    prdata = {48'd0, cfg_r.base};
      REG_RESMIN:  prdata = {48'd0, cfg_r.resmin};
      REG_ALPHA:   prdata = {48'd0, cfg_r.alpha};
      REG_MARGINS: prdata = {32'd0, cfg_r.margins};
      REG_DWELL:   prdata = {56'd0, cfg_r.dwell};
      default:     prdata = '0;
    endcase
  end

  assign cfg           = cfg_r;
  assign evt.seed      = wr && (idx == REG_BASE);
  assign evt.seed_val  = pwdata[15:0];
  assign evt.dwell_ld  = wr && (idx == REG_DWELL);
  assign evt.dwell_val = pwdata[7:0];

endmodule

// File: rtl/qlbg_dp.sv
`timescale 1ns / 1ps
module qlbg_dp import qlbg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  cfg_evt_t         evt,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [15:0]      in_measured_cost,
  input  logic             in_measurement_valid,
  input  logic [15:0]      in_new_allocation,
  input  logic             in_allocation_valid,
  input  logic             in_relax_grant,
  input  logic             in_restore_request,
  input  logic             in_pinned_mode,
  output logic [15:0]      out_filtered_cost,
  output logic [POS_W-1:0] out_old_position,
  output logic [POS_W-1:0] out_new_position,
  output logic [15:0]      out_predicted_cost,
  output logic             out_tightened,
  output logic             out_relaxed,
  output logic             out_at_cheapest,
  output logic             out_at_reserved_floor,
  output logic [15:0]      out_pinned_overrun
);

  // architectural state
  logic [15:0]      filt_r, filt_nxt;
  logic [15:0]      scale_r, scale_nxt;
  logic [15:0]      alloc_r, alloc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       dwell_r, dwell_nxt;
  logic             seen_r, seen_nxt;
  logic             gp_r, gp_nxt;

  // request and working registers
  logic [15:0]      meas_r, meas_nxt;
  logic             meas_ok_r, meas_ok_nxt;
  logic [15:0]      nalloc_r, nalloc_nxt;
  logic             alloc_ok_r, alloc_ok_nxt;
  logic             grant_r, grant_nxt;
  logic             restore_r, restore_nxt;
  logic             pinned_r, pinned_nxt;
  logic [32:0]      acc_r, acc_nxt;
  logic [16:0]      rem_r, rem_nxt;
  logic [30:0]      dvd_r, dvd_nxt;
  logic [15:0]      dc_r, dc_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [15:0]      pred_r, pred_nxt;
  logic [POS_W-1:0] from_r, from_nxt;
  logic             tight_r, tight_nxt;
  logic             relax_r, relax_nxt;
  logic [15:0]      ovr_r, ovr_nxt;

  // result register
  logic [15:0]      o_filt_r, o_filt_nxt;
  logic [POS_W-1:0] o_from_r, o_from_nxt;
  logic [POS_W-1:0] o_to_r, o_to_nxt;
  logic [15:0]      o_pred_r, o_pred_nxt;
  logic             o_tight_r, o_tight_nxt;
  logic             o_relax_r, o_relax_nxt;
  logic             o_cheap_r, o_cheap_nxt;
  logic             o_floor_r, o_floor_nxt;
  logic [15:0]      o_ovr_r, o_ovr_nxt;

  logic [16:0]      mul_a;
  logic [15:0]      mul_b;
  logic [32:0]      prod;
  logic [32:0]      rnd;
  logic [15:0]      pred_sat;
  logic [33:0]      fsum;
  logic [16:0]      trial;
  logic             ge;
  logic [15:0]      cost_cur;
  logic [15:0]      cost_dn;
  logic             at_last;
  logic [7:0]       dwell_inc;
  logic             gp_now;
  logic             tight_go;
  logic             relax_go;
  logic [15:0]      tm;
  logic [15:0]      rm;

  assign tm        = cfg.margins[15:0];
  assign rm        = cfg.margins[31:16];
  assign cost_cur  = cost_of(cfg, pos_r);
  assign cost_dn   = cost_of(cfg, pos_r - POS_W'(1));
  assign at_last   = pos_r >= last_pos(cfg.length);
  assign dwell_inc = (dwell_r < cfg.dwell) ? dwell_r + 8'd1 : dwell_r;
  assign gp_now    = gp_r | grant_r;

  // shared multiplier
  always_comb begin
    case (cmd.op)
      OP_MUL1:  begin mul_a = 17'h10000 - {1'b0, cfg.alpha}; mul_b = filt_r;   end
      OP_MUL2:  begin mul_a = {1'b0, cfg.alpha};             mul_b = meas_r;   end
      OP_TIGHT: begin mul_a = {1'b0, alloc_r};               mul_b = tm;       end
      OP_RPRED: begin mul_a = {1'b0, scale_r};               mul_b = cost_dn;  end
      OP_RFIT:  begin mul_a = {1'b0, alloc_r};               mul_b = rm;       end
      OP_PRED:  begin mul_a = {1'b0, scale_r};               mul_b = cost_cur; end
      default:  begin mul_a = '0;                            mul_b = '0;       end
    endcase
  end

  assign prod     = mul_a * {17'd0, mul_b};
  assign rnd      = prod + 33'd16384;
  assign pred_sat = (|rnd[32:31]) ? 16'hFFFF : rnd[30:15];
  assign fsum     = {1'b0, acc_r} + {1'b0, prod} + 34'd32768;
  assign trial    = {rem_r[15:0], dvd_r[30]};
  assign ge       = trial >= {1'b0, dc_r};

  assign tight_go = ({3'd0, filt_r, 14'd0} > prod) && !at_last;
  assign relax_go = !tight_go && gp_now && (pos_r != '0) && (dwell_inc >= cfg.dwell);

  always_comb begin
    filt_nxt     = filt_r;
    scale_nxt    = scale_r;
    alloc_nxt    = alloc_r;
    pos_nxt      = pos_r;
    dwell_nxt    = dwell_r;
    seen_nxt     = seen_r;
    gp_nxt       = gp_r;
    meas_nxt     = meas_r;
    meas_ok_nxt  = meas_ok_r;
    nalloc_nxt   = nalloc_r;
    alloc_ok_nxt = alloc_ok_r;
    grant_nxt    = grant_r;
    restore_nxt  = restore_r;
    pinned_nxt   = pinned_r;
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    dc_nxt       = dc_r;
    cnt_nxt      = cnt_r;
    pred_nxt     = pred_r;
    from_nxt     = from_r;
    tight_nxt    = tight_r;
    relax_nxt    = relax_r;
    ovr_nxt      = ovr_r;
    o_filt_nxt   = o_filt_r;
    o_from_nxt   = o_from_r;
    o_to_nxt     = o_to_r;
    o_pred_nxt   = o_pred_r;
    o_tight_nxt  = o_tight_r;
    o_relax_nxt  = o_relax_r;
    o_cheap_nxt  = o_cheap_r;
    o_floor_nxt  = o_floor_r;
    o_ovr_nxt    = o_ovr_r;
    case (cmd.op)
      OP_LOAD: begin
        meas_nxt     = in_measured_cost;
        meas_ok_nxt  = in_measurement_valid;
        nalloc_nxt   = in_new_allocation;
        alloc_ok_nxt = in_allocation_valid;
        grant_nxt    = in_relax_grant;
        restore_nxt  = in_restore_request;
        pinned_nxt   = in_pinned_mode;
      end
      OP_PRE: begin
        if (restore_r) begin
          pos_nxt   = '0;
          dwell_nxt = cfg.dwell;
          gp_nxt    = 1'b0;
        end
        if (alloc_ok_r) begin
          alloc_nxt = (nalloc_r > cfg.resmin) ? nalloc_r : cfg.resmin;
        end
        // first sample loads the filter directly
        if (meas_ok_r && !seen_r) begin
          filt_nxt = meas_r;
          seen_nxt = 1'b1;
        end
      end
      OP_MUL1: acc_nxt = prod;
      OP_MUL2: filt_nxt = fsum[31:16];
      OP_DIVINIT: begin
        rem_nxt = '0;
        dvd_nxt = {filt_r, 15'd0};
        dc_nxt  = cost_cur;
        cnt_nxt = 5'd30;
      end
      OP_DIVSTEP: begin
        rem_nxt = ge ? trial - {1'b0, dc_r} : trial;
        dvd_nxt = {dvd_r[29:0], ge};
        cnt_nxt = cnt_r - 5'd1;
      end
      OP_DIVEND: begin
        if (dvd_r != '0) begin
          scale_nxt = (|dvd_r[30:16]) ? 16'hFFFF : dvd_r[15:0];
        end
      end
      OP_TIGHT: begin
        gp_nxt    = gp_now;
        from_nxt  = pos_r;
        tight_nxt = 1'b0;
        relax_nxt = 1'b0;
        ovr_nxt   = '0;
        if (pinned_r) begin
          if (filt_r > alloc_r) begin
            ovr_nxt = filt_r - alloc_r;
          end
        end else begin
          dwell_nxt = dwell_inc;
          if (tight_go) begin
            pos_nxt   = pos_r + POS_W'(1);
            tight_nxt = 1'b1;
            dwell_nxt = '0;
          end else if (relax_go) begin
            // grant is spent whether or not the step fires
            gp_nxt = 1'b0;
          end
        end
      end
      OP_RPRED: pred_nxt = pred_sat;
      OP_RFIT: begin
        if ({3'd0, pred_r, 14'd0} <= prod) begin
          pos_nxt   = pos_r - POS_W'(1);
          relax_nxt = 1'b1;
          dwell_nxt = '0;
        end
      end
      OP_PRED: pred_nxt = pred_sat;
      OP_OUT: begin
        o_filt_nxt  = filt_r;
        o_from_nxt  = from_r;
        o_to_nxt    = pos_r;
        o_pred_nxt  = pred_r;
        o_tight_nxt = tight_r;
        o_relax_nxt = relax_r;
        o_cheap_nxt = at_last;
        o_floor_nxt = alloc_r <= cfg.resmin;
        o_ovr_nxt   = ovr_r;
      end
      default: ;
    endcase
    if (evt.seed) begin
      filt_nxt  = evt.seed_val;
      scale_nxt = evt.seed_val;
      alloc_nxt = evt.seed_val;
      seen_nxt  = 1'b0;
    end
    if (evt.dwell_ld) begin
      dwell_nxt = evt.dwell_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r  <= BASE_RST;
      scale_r <= BASE_RST;
      alloc_r <= BASE_RST;
      pos_r   <= '0;
      dwell_r <= DWELL_RST;
      seen_r  <= 1'b0;
      gp_r    <= 1'b0;
    end else begin
      filt_r  <= filt_nxt;
      scale_r <= scale_nxt;
      alloc_r <= alloc_nxt;
      pos_r   <= pos_nxt;
      dwell_r <= dwell_nxt;
      seen_r  <= seen_nxt;
      gp_r    <= gp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r     <= meas_nxt;
    meas_ok_r  <= meas_ok_nxt;
    nalloc_r   <= nalloc_nxt;
    alloc_ok_r <= alloc_ok_nxt;
    grant_r    <= grant_nxt;
    restore_r  <= restore_nxt;
    pinned_r   <= pinned_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    dc_r       <= dc_nxt;
    cnt_r      <= cnt_nxt;
    pred_r     <= pred_nxt;
    from_r     <= from_nxt;
    tight_r    <= tight_nxt;
    relax_r    <= relax_nxt;
    ovr_r      <= ovr_nxt;
    o_filt_r   <= o_filt_nxt;
    o_from_r   <= o_from_nxt;
    o_to_r     <= o_to_nxt;
    o_pred_r   <= o_pred_nxt;
    o_tight_r  <= o_tight_nxt;
    o_relax_r  <= o_relax_nxt;
    o_cheap_r  <= o_cheap_nxt;
    o_floor_r  <= o_floor_nxt;
    o_ovr_r    <= o_ovr_nxt;
  end

  assign sts.meas_ok   = meas_ok_r;
  assign sts.seen      = seen_r;
  assign sts.cost_zero = (cost_cur == '0);
  assign sts.div_last  = (cnt_r == '0);
  assign sts.pinned    = pinned_r;
  assign sts.relax_go  = relax_go;

  assign out_filtered_cost     = o_filt_r;
  assign out_old_position      = o_from_r;
  assign out_new_position      = o_to_r;
  assign out_predicted_cost    = o_pred_r;
  assign out_tightened         = o_tight_r;
  assign out_relaxed           = o_relax_r;
  assign out_at_cheapest       = o_cheap_r;
  assign out_at_reserved_floor = o_floor_r;
  assign out_pinned_overrun    = o_ovr_r;

endmodule

// File: rtl/qlbg_ctrl.sv
`timescale 1ns / 1ps
module qlbg_ctrl import qlbg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PRE     = 4'd1;
  localparam logic [3:0] S_MUL1    = 4'd2;
  localparam logic [3:0] S_MUL2    = 4'd3;
  localparam logic [3:0] S_DIVINIT = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_DIVEND  = 4'd6;
  localparam logic [3:0] S_TIGHT   = 4'd7;
  localparam logic [3:0] S_RPRED   = 4'd8;
  localparam logic [3:0] S_RFIT    = 4'd9;
  localparam logic [3:0] S_PRED    = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        cmd.op = OP_PRE;
        if (!sts.meas_ok) begin
          state_nxt = S_TIGHT;
        end else if (sts.seen) begin
          state_nxt = S_MUL1;
        end else begin
          state_nxt = S_DIVINIT;
        end
      end
      S_MUL1: begin
        cmd.op    = OP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = OP_MUL2;
        state_nxt = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.op    = OP_DIVINIT;
        state_nxt = sts.cost_zero ? S_TIGHT : S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIVSTEP;
        if (sts.div_last) begin
          state_nxt = S_DIVEND;
        end
      end
      S_DIVEND: begin
        cmd.op    = OP_DIVEND;
        state_nxt = S_TIGHT;
      end
      S_TIGHT: begin
        cmd.op = OP_TIGHT;
        if (!sts.pinned && sts.relax_go) begin
          state_nxt = S_RPRED;
        end else begin
          state_nxt = S_PRED;
        end
      end
      S_RPRED: begin
        cmd.op    = OP_RPRED;
        state_nxt = S_RFIT;
      end
      S_RFIT: begin
        cmd.op    = OP_RFIT;
        state_nxt = S_PRED;
      end
      S_PRED: begin
        cmd.op    = OP_PRED;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (state_r == S_OUT && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_PRE)
    else $error("accepted request did not start processing");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && !sts.div_last |=> state_r == S_DIV)
    else $error("divider left before its last step");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("result not presented after completion");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside completion step");

endmodule

// File: rtl/quality_ladder_budget_governor_unit.sv
`timescale 1ns / 1ps
// Frame-rate quality ladder governor: each request carries one frame's measured cost,
// allocation and control flags and yields one result. Its processing time is set mainly
// by the 31-step restoring divider that re-estimates the scale (skipped when no
// measurement arrives or the position cost is zero), plus single steps on one shared
// 17x16 multiplier for filter, margin and prediction terms. One request is in flight
// at a time; the next is taken while a finished result waits in the output register.
// Registers sit at byte address 8*index on the 64-bit port; the user must write them
// only while the block is idle, as the block itself does not enforce this.
module quality_ladder_budget_governor_unit import qlbg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_measured_cost,
  input  logic              in_measurement_valid,
  input  logic [15:0]       in_new_allocation,
  input  logic              in_allocation_valid,
  input  logic              in_relax_grant,
  input  logic              in_restore_request,
  input  logic              in_pinned_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_filtered_cost,
  output logic [POS_W-1:0]  out_old_position,
  output logic [POS_W-1:0]  out_new_position,
  output logic [15:0]       out_predicted_cost,
  output logic              out_tightened,
  output logic              out_relaxed,
  output logic              out_at_cheapest,
  output logic              out_at_reserved_floor,
  output logic [15:0]       out_pinned_overrun,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  cfg_evt_t evt;
  cmd_t     cmd;
  sts_t     sts;

  qlbg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .evt     (evt)
  );

  qlbg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qlbg_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .evt                   (evt),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_measured_cost      (in_measured_cost),
    .in_measurement_valid  (in_measurement_valid),
    .in_new_allocation     (in_new_allocation),
    .in_allocation_valid   (in_allocation_valid),
    .in_relax_grant        (in_relax_grant),
    .in_restore_request    (in_restore_request),
    .in_pinned_mode        (in_pinned_mode),
    .out_filtered_cost     (out_filtered_cost),
    .out_old_position      (out_old_position),
    .out_new_position      (out_new_position),
    .out_predicted_cost    (out_predicted_cost),
    .out_tightened         (out_tightened),
    .out_relaxed           (out_relaxed),
    .out_at_cheapest       (out_at_cheapest),
    .out_at_reserved_floor (out_at_reserved_floor),
    .out_pinned_overrun    (out_pinned_overrun)
  );

endmodule

// File: bench/quality_ladder_budget_governor_unit_tb.sv
`timescale 1ns / 1ps
module quality_ladder_budget_governor_unit_tb;
  import qlbg_pkg::*;

  typedef struct packed {
    logic [15:0] meas;
    logic        meas_ok;
    logic [15:0] alloc;
    logic        alloc_ok;
    logic        grant;
    logic        restore;
    logic        pinned;
  } frame_t;

  typedef struct packed {
    logic [15:0]      filtered;
    logic [POS_W-1:0] from_pos;
    logic [POS_W-1:0] to_pos;
    logic [15:0]      predicted;
    logic             tightened;
    logic             relaxed;
    logic             at_cheapest;
    logic             at_floor;
    logic [15:0]      overrun;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_measured_cost = '0;
  logic in_measurement_valid = 1'b0;
  logic [15:0] in_new_allocation = '0;
  logic in_allocation_valid = 1'b0;
  logic in_relax_grant = 1'b0;
  logic in_restore_request = 1'b0;
  logic in_pinned_mode = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_filtered_cost;
  logic [POS_W-1:0] out_old_position;
  logic [POS_W-1:0] out_new_position;
  logic [15:0] out_predicted_cost;
  logic out_tightened;
  logic out_relaxed;
  logic out_at_cheapest;
  logic out_at_reserved_floor;
  logic [15:0] out_pinned_overrun;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  quality_ladder_budget_governor_unit dut (.*);

  always #4 clk = ~clk;

  // governor copy: configuration
  logic [63:0] g_cost_lo, g_cost_hi;
  logic [3:0]  g_length;
  logic [15:0] g_base, g_resmin, g_alpha;
  logic [31:0] g_margins;
  logic [7:0]  g_dwell_cfg;
  // governor copy: state
  logic [15:0] g_filtered, g_scale, g_alloc;
  logic [2:0]  g_pos;
  logic [7:0]  g_dwell;
  logic        g_seen, g_grant;

  frame_t   pending_frames[$];
  verdict_t expected_verdicts[$];
  int       errors = 0;
  int       sender_idle_pct = 0;
  int       receiver_idle_pct = 0;
  bit       sender_hold = 1'b0;
  longint   cycle_count = 0;

  function automatic logic [2:0] g_last();
    if (g_length == 0) return 3'd0;
    if (g_length > 8) return 3'd7;
    return 3'(g_length - 1);
  endfunction

  function automatic logic [15:0] g_cost(input logic [2:0] pos);
    logic [2:0] idx;
    logic [127:0] both;
    idx = (pos < g_last()) ? pos : g_last();
    both = {g_cost_hi, g_cost_lo};
    return both[idx*16 +: 16];
  endfunction

  function automatic logic [15:0] g_predict(input logic [2:0] pos);
    logic [47:0] p;
    p = (48'(g_scale) * g_cost(pos) + 48'd16384) >> 15;
    return (p > 48'hFFFF) ? 16'hFFFF : p[15:0];
  endfunction

  task automatic seed_governor();
    g_filtered = g_base;
    g_scale = g_base;
    g_alloc = g_base;
    g_seen = 1'b0;
  endtask

  task automatic apply_register(input logic [2:0] idx, input logic [63:0] v);
    case (idx)
      REG_COST_LO: g_cost_lo = v;
      REG_COST_HI: g_cost_hi = v;
      REG_LENGTH:  g_length = v[3:0];
      REG_BASE: begin
        g_base = v[15:0];
        seed_governor();
      end
      REG_RESMIN:  g_resmin = v[15:0];
      REG_ALPHA:   g_alpha = v[15:0];
      REG_MARGINS: g_margins = v[31:0];
      REG_DWELL: begin
        g_dwell_cfg = v[7:0];
        g_dwell = v[7:0];
      end
      default: ;
    endcase
  endtask

  function automatic verdict_t govern_frame(input frame_t f);
    verdict_t r;
    logic [15:0] c;
    logic [63:0] acc, q;
    logic [2:0]  cand;
    r = '0;
    if (f.restore) begin
      g_pos = '0;
      g_dwell = g_dwell_cfg;
      g_grant = 1'b0;
    end
    if (f.alloc_ok) g_alloc = (f.alloc > g_resmin) ? f.alloc : g_resmin;
    if (f.meas_ok) begin
      if (!g_seen) begin
        g_filtered = f.meas;
        g_seen = 1'b1;
      end else begin
        acc = 64'(g_filtered) * (64'd65536 - g_alpha) + 64'(f.meas) * g_alpha + 64'd32768;
        g_filtered = acc[31:16];
      end
      c = g_cost(g_pos);
      if (c != 0) begin
        q = (64'(g_filtered) << 15) / c;
        if (q > 64'hFFFF) q = 64'hFFFF;
        if (q != 0) g_scale = q[15:0];
      end
    end
    if (f.grant) g_grant = 1'b1;
    r.from_pos = g_pos;
    if (f.pinned) begin
      if (g_filtered > g_alloc) r.overrun = g_filtered - g_alloc;
    end else begin
      if (g_dwell < g_dwell_cfg) g_dwell++;
      if ((64'(g_filtered) << 14) > 64'(g_alloc) * g_margins[15:0] && g_pos < g_last()) begin
        g_pos++;
        r.tightened = 1'b1;
        g_dwell = '0;
      end else if (g_grant && g_pos > 0 && g_dwell >= g_dwell_cfg) begin
        cand = g_pos - 3'd1;
        if ((64'(g_predict(cand)) << 14) <= 64'(g_alloc) * g_margins[31:16]) begin
          g_pos = cand;
          r.relaxed = 1'b1;
          g_dwell = '0;
        end
        g_grant = 1'b0;
      end
    end
    r.filtered = g_filtered;
    r.to_pos = g_pos;
    r.predicted = g_predict(g_pos);
    r.at_cheapest = (g_pos >= g_last());
    r.at_floor = (g_alloc <= g_resmin);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (pending_frames.size() > 0 && !sender_hold &&
            $urandom_range(99) >= sender_idle_pct) begin
          frame_t f;
          f = pending_frames.pop_front();
          expected_verdicts.push_back(govern_frame(f));
          in_valid <= 1'b1;
          in_measured_cost <= f.meas;
          in_measurement_valid <= f.meas_ok;
          in_new_allocation <= f.alloc;
          in_allocation_valid <= f.alloc_ok;
          in_relax_grant <= f.grant;
          in_restore_request <= f.restore;
          in_pinned_mode <= f.pinned;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result", 16'd1, 16'd0);
      end else begin
        verdict_t e;
        e = expected_verdicts.pop_front();
        if (out_filtered_cost !== e.filtered)
          report_mismatch("filtered_cost", out_filtered_cost, e.filtered);
        if (out_old_position !== e.from_pos)
          report_mismatch("old_position", 16'(out_old_position), 16'(e.from_pos));
        if (out_new_position !== e.to_pos)
          report_mismatch("new_position", 16'(out_new_position), 16'(e.to_pos));
        if (out_predicted_cost !== e.predicted)
          report_mismatch("predicted_cost", out_predicted_cost, e.predicted);
        if (out_tightened !== e.tightened)
          report_mismatch("tightened", 16'(out_tightened), 16'(e.tightened));
        if (out_relaxed !== e.relaxed)
          report_mismatch("relaxed", 16'(out_relaxed), 16'(e.relaxed));
        if (out_at_cheapest !== e.at_cheapest)
          report_mismatch("at_cheapest", 16'(out_at_cheapest), 16'(e.at_cheapest));
        if (out_at_reserved_floor !== e.at_floor)
          report_mismatch("at_reserved_floor", 16'(out_at_reserved_floor), 16'(e.at_floor));
        if (out_pinned_overrun !== e.overrun)
          report_mismatch("pinned_overrun", out_pinned_overrun, e.overrun);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_frames.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [63:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_register(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    f.meas = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1200));
    f.meas_ok = ($urandom_range(3) != 0);
    f.alloc = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1200));
    f.alloc_ok = ($urandom_range(2) == 0);
    f.grant = ($urandom_range(2) == 0);
    f.restore = ($urandom_range(19) == 0);
    f.pinned = ($urandom_range(9) == 0);
    return f;
  endfunction

  function automatic logic [63:0] random_costs();
    logic [63:0] v;
    for (int k = 0; k < 4; k++)
      v[k*16 +: 16] = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 40000));
    return v;
  endfunction

  task automatic random_settings(input int kind);
    write_register(REG_COST_LO, kind == 0 ? 64'hFFFF_0000_FFFF_0001 : random_costs());
    write_register(REG_COST_HI, kind == 0 ? 64'h0001_FFFF_0000_8000 : random_costs());
    write_register(REG_LENGTH, kind == 0 ? 64'd15 : 64'($urandom_range(15)));
    write_register(REG_ALPHA, kind == 0 ? 64'hFFFF : 64'($urandom));
    write_register(REG_MARGINS, kind == 0 ? 64'hFFFF_0000 :
                   {32'd0, 16'($urandom_range(8192, 24000)), 16'($urandom_range(10000, 24000))});
    write_register(REG_RESMIN, kind == 0 ? 64'hFFFF : 64'($urandom_range(0, 400)));
    write_register(REG_DWELL, kind == 0 ? 64'hFF : 64'($urandom_range(0, 5)));
    write_register(REG_BASE, kind == 0 ? 64'd1 : 64'($urandom_range(1, 65535)));
  endtask

  initial begin
    frame_t f;
    g_cost_lo = COST_RST;
    g_cost_hi = COST_RST;
    g_length = LENGTH_RST;
    g_base = BASE_RST;
    g_resmin = RESMIN_RST;
    g_alpha = ALPHA_RST;
    g_margins = MARGINS_RST;
    g_dwell_cfg = DWELL_RST;
    seed_governor();
    g_pos = '0;
    g_dwell = DWELL_RST;
    g_grant = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 8 positions, zero cost word, low tightening and high relaxing margin to force moves
    write_register(REG_COST_LO, 64'h1000_0000_4000_8000);
    write_register(REG_COST_HI, 64'h0400_FFFF_0800_0001);
    write_register(REG_LENGTH, 64'd8);
    write_register(REG_MARGINS, 64'hFFFF_2000);
    write_register(REG_ALPHA, 64'd0);
    write_register(REG_DWELL, 64'd2);
    write_register(REG_RESMIN, 64'd100);
    write_register(REG_BASE, 64'd256);
    sender_idle_pct = 36;
    receiver_idle_pct = 74;
    pending_frames.push_back('{16'hFFFF, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0});
    pending_frames.push_back('{16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0});
    for (int k = 0; k < 9; k++)
      pending_frames.push_back('{16'd2000, 1'b1, 16'd200, 1'b1, 1'b0, 1'b0, 1'b0});
    pending_frames.push_back('{16'd3000, 1'b1, 16'd100, 1'b1, 1'b0, 1'b0, 1'b1});
    pending_frames.push_back('{16'd0, 1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1});
    for (int k = 0; k < 5; k++)
      pending_frames.push_back('{16'd10, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0});
    pending_frames.push_back('{16'd50, 1'b1, 16'd300, 1'b0, 1'b1, 1'b1, 1'b0});
    pending_frames.push_back('{16'd1, 1'b1, 16'd1, 1'b1, 1'b0, 1'b0, 1'b0});
    drain();
    // shrink the ladder below the current position
    write_register(REG_LENGTH, 64'd0);
    write_register(REG_ALPHA, 64'hFFFF);
    pending_frames.push_back('{16'hFFFF, 1'b1, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0});
    pending_frames.push_back('{16'h8000, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0});
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      random_settings(phase == 1 ? 0 : 1);
      if (phase == 2) begin
        sender_idle_pct = 74;
        receiver_idle_pct = 36;
      end else if (phase == 4) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      for (int k = 0; k < 135; k++) begin
        f = random_frame();
        pending_frames.push_back(f);
      end
      while (pending_frames.size() > 70) @(posedge clk);
      // hold the sender until the block has delivered everything
      sender_hold = 1'b1;
      while (in_valid || expected_verdicts.size() > 0) @(posedge clk);
      sender_hold = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/qlbg_pkg.sv
rtl/qlbg_regs.sv
rtl/qlbg_dp.sv
rtl/qlbg_ctrl.sv
rtl/quality_ladder_budget_governor_unit.sv
bench/quality_ladder_budget_governor_unit_tb.sv
